@@ src/dday_pkg.sv @@
// ----------------------------------------------------------------------------
// Date day difference package
// Field widths, pipeline depth, the stage control group and the table of
// days before each month.
// ----------------------------------------------------------------------------
package dday_pkg;

    localparam int DDAY_MONTH_W    = 4;
    localparam int DDAY_DAY_W      = 7;
    localparam int DDAY_YEAR_W     = 14;
    localparam int DDAY_DIFF_W     = 23;
    localparam int DDAY_PART_W     = 9;
    localparam int DDAY_STAGES     = 4;
    localparam int DDAY_EPOCH_YEAR = 1970;

    // Advance enables, one per register stage, from first to last.
    typedef struct packed {
        logic [DDAY_STAGES-1:0] adv;
    } dday_ctrl_t;

    // Days before the first of the month in a common year. Month zero adds
    // nothing and months above twelve count as December.
    function automatic logic [DDAY_PART_W-1:0] days_before_month(
        input logic [DDAY_MONTH_W-1:0] month
    );
        logic [DDAY_PART_W-1:0] days;
        case (month)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            default: days = 9'd334;
        endcase
        return days;
    endfunction

endpackage

@@ src/dday_in_if.sv @@
// ----------------------------------------------------------------------------
// Date pair channel
// Valid/ready channel carrying the two dates of one item.
// ----------------------------------------------------------------------------
interface dday_in_if;
    import dday_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [DDAY_MONTH_W-1:0] first_month;
    logic [DDAY_DAY_W-1:0]   first_day;
    logic [DDAY_YEAR_W-1:0]  first_year;
    logic [DDAY_MONTH_W-1:0] last_month;
    logic [DDAY_DAY_W-1:0]   last_day;
    logic [DDAY_YEAR_W-1:0]  last_year;

    modport source (
        output valid, first_month, first_day, first_year,
        output last_month, last_day, last_year,
        input  ready
    );

    modport sink (
        input  valid, first_month, first_day, first_year,
        input  last_month, last_day, last_year,
        output ready
    );
endinterface

@@ src/dday_out_if.sv @@
// ----------------------------------------------------------------------------
// Day difference channel
// Valid/ready channel carrying the signed day count of one item.
// ----------------------------------------------------------------------------
interface dday_out_if;
    import dday_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [DDAY_DIFF_W-1:0] day_difference;

    modport source (
        output valid, day_difference,
        input  ready
    );

    modport sink (
        input  valid, day_difference,
        output ready
    );
endinterface

@@ src/dday_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pipeline control
// Valid bits for every stage and the advance enables that let a stage load
// when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module dday_pipe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output dday_pkg::dday_ctrl_t ctrl
);
    import dday_pkg::*;

    logic [DDAY_STAGES-1:0] valid_reg;
    logic [DDAY_STAGES-1:0] valid_next;
    logic [DDAY_STAGES-1:0] adv;

    always_comb
    begin
        adv[DDAY_STAGES-1] = !valid_reg[DDAY_STAGES-1] || out_ready;
        for (int k = DDAY_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < DDAY_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.adv  = adv;
    assign in_ready  = adv[0];
    assign out_valid = valid_reg[DDAY_STAGES-1];

    // A stalled second stage keeps its item.
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !adv[1] |=> valid_reg[1])
        else $error("stalled stage lost its item");

    // An accepted item occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item did not enter the pipeline");

    // A full pipeline with a blocked output takes no new item.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("full pipeline accepted an item");

    // Items move forward one stage at a time: the last stage, advancing while
    // the stage before it was full, becomes full.
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && adv[3] |=> valid_reg[3])
        else $error("item dropped between the last two stages");
endmodule

@@ src/dday_date_pipe.sv @@
// ----------------------------------------------------------------------------
// Day number pipeline
// Three register stages that turn one date into its day count from the epoch.
// ----------------------------------------------------------------------------
module dday_date_pipe #(
    parameter int EPOCH_YEAR = dday_pkg::DDAY_EPOCH_YEAR
) (
    input  logic                             clk,
    input  dday_pkg::dday_ctrl_t             ctrl,
    input  logic [dday_pkg::DDAY_MONTH_W-1:0] month,
    input  logic [dday_pkg::DDAY_DAY_W-1:0]   day,
    input  logic [dday_pkg::DDAY_YEAR_W-1:0]  year,
    output logic [dday_pkg::DDAY_DIFF_W-1:0]  day_number
);
    import dday_pkg::*;

    localparam int Q4_W   = DDAY_YEAR_W - 2;
    localparam int Q100_W = 8;
    localparam int DIV25_MUL   = 1311;
    localparam int DIV25_SHIFT = 15;
    localparam int EPOCH_LEAPS_INT =
        (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;
    localparam logic [Q4_W-1:0]        EPOCH_LEAPS = Q4_W'(EPOCH_LEAPS_INT);
    localparam logic [DDAY_YEAR_W-1:0] EPOCH_Y     = DDAY_YEAR_W'(EPOCH_YEAR);

    // Stage 1: month offset plus day, and year/4 times the reciprocal of 25.
    logic [DDAY_YEAR_W-1:0] year_s1_reg;
    logic [DDAY_DIFF_W-1:0] prod_s1_reg, prod_s1_next;
    logic [DDAY_PART_W-1:0] part_s1_reg, part_s1_next;
    logic                   after_feb_s1_reg;

    always_comb
    begin
        prod_s1_next = DDAY_DIFF_W'(year[DDAY_YEAR_W-1:2]) * DDAY_DIFF_W'(DIV25_MUL);
        part_s1_next = days_before_month(month) + DDAY_PART_W'(day);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[0])
        begin
            year_s1_reg      <= year;
            prod_s1_reg      <= prod_s1_next;
            part_s1_reg      <= part_s1_next;
            after_feb_s1_reg <= month > 4'd2;
        end
    end

    // Stage 2: leap rule and the closed-form leap count since the epoch.
    logic [Q4_W-1:0]        q4;
    logic [Q100_W-1:0]      q100;
    logic [Q4_W:0]          q100x25;
    logic                   century;
    logic                   leap;
    logic                   later;
    logic [Q4_W-1:0]        leaps_thru;
    logic [DDAY_YEAR_W-1:0] whole_s2_reg, whole_s2_next;
    logic [Q4_W-1:0]        leaps_s2_reg, leaps_s2_next;
    logic [DDAY_PART_W-1:0] part_s2_reg, part_s2_next;

    always_comb
    begin
        q4      = year_s1_reg[DDAY_YEAR_W-1:2];
        q100    = prod_s1_reg[DIV25_SHIFT +: Q100_W];
        q100x25 = {1'b0, q100, 4'b0000} + {2'b00, q100, 3'b000} + (Q4_W+1)'(q100);
        century = {1'b0, q4} == q100x25;
        leap    = (year_s1_reg[1:0] == 2'b00) && (!century || q100[1:0] == 2'b00);
        // Leap years in 1..year, less this year itself, gives 1..year-1.
        leaps_thru = q4 - Q4_W'(q100) + Q4_W'(q100[Q100_W-1:2]) - Q4_W'(leap);
        later   = year_s1_reg > EPOCH_Y;
        whole_s2_next = later ? year_s1_reg - EPOCH_Y : '0;
        leaps_s2_next = later ? leaps_thru - EPOCH_LEAPS : '0;
        part_s2_next  = part_s1_reg + DDAY_PART_W'(after_feb_s1_reg && leap);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[1])
        begin
            whole_s2_reg <= whole_s2_next;
            leaps_s2_reg <= leaps_s2_next;
            part_s2_reg  <= part_s2_next;
        end
    end

    // Stage 3: whole years times 365, plus leap days and the in-year part.
    logic [DDAY_DIFF_W-1:0] day_number_reg, day_number_next;

    always_comb
    begin
        day_number_next = DDAY_DIFF_W'(whole_s2_reg) * DDAY_DIFF_W'(365)
                        + DDAY_DIFF_W'(leaps_s2_reg) + DDAY_DIFF_W'(part_s2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[2])
        begin
            day_number_reg <= day_number_next;
        end
    end

    assign day_number = day_number_reg;
endmodule

@@ src/date_day_difference.sv @@
// ----------------------------------------------------------------------------
// Date day difference
// Signed number of days from the first of two dates to the last.
// ----------------------------------------------------------------------------
// The block takes one pair of dates per item and returns the day count of
// the last date minus that of the first, as a 23-bit two's complement value
// that wraps on overflow. Each date is counted in days from EPOCH_YEAR under
// the Gregorian leap rule; years at or before the epoch add no whole-year
// days, months above twelve count as December, month zero adds no month
// lengths and the day is added as given. An item may be offered on every
// clock cycle and the block sustains one item per cycle while the result
// is taken. The block has four register stages: the divide-by-25
// reciprocal multiply, the leap-year logic, the multiply by 365 and the
// final subtraction into the output register. A stalled output holds the
// pipeline in place, so no item is lost or repeated, and the input stays
// ready while any stage is free.
// ----------------------------------------------------------------------------
module date_day_difference #(
    parameter int EPOCH_YEAR = dday_pkg::DDAY_EPOCH_YEAR
) (
    input  logic       clk,
    input  logic       rst_n,
    dday_in_if.sink    dates,
    dday_out_if.source result
);
    import dday_pkg::*;

    dday_ctrl_t             ctrl;
    logic [DDAY_DIFF_W-1:0] first_number;
    logic [DDAY_DIFF_W-1:0] last_number;
    logic [DDAY_DIFF_W-1:0] diff_reg, diff_next;

    // Valid bits and stall handling for all four stages.
    dday_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dates.valid),
        .in_ready  (dates.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    // The two dates run through identical pipelines side by side.
    dday_date_pipe #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_first (
        .clk        (clk),
        .ctrl       (ctrl),
        .month      (dates.first_month),
        .day        (dates.first_day),
        .year       (dates.first_year),
        .day_number (first_number)
    );

    dday_date_pipe #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_last (
        .clk        (clk),
        .ctrl       (ctrl),
        .month      (dates.last_month),
        .day        (dates.last_day),
        .year       (dates.last_year),
        .day_number (last_number)
    );

    // The subtraction wraps modulo two to the 23rd, which is exactly the
    // two's complement result.
    always_comb
    begin
        diff_next = last_number - first_number;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[DDAY_STAGES-1])
        begin
            diff_reg <= diff_next;
        end
    end

    assign result.day_difference = $signed(diff_reg);
endmodule
